// ===== rtl/core/bfre_pkg.sv =====
// Shared constants and types for the bitmap free-range extractor.
// No dependencies; used by every module under rtl/core.
package bfre_pkg;

  localparam int BYTE_W       = 8;   // bitmap bits per item
  localparam int BIT_IDX_W    = 3;   // bit index within a byte
  localparam int POS_W        = 32;  // bit position counter
  localparam int BCNT_W       = POS_W - BIT_IDX_W;  // byte count part of the position
  localparam int ID_OUT_W     = 32;  // width of range_start / range_end
  localparam int BASE_W       = 32;  // width of the base_id register
  localparam int MAX_RANGES   = 5;   // most ranges one byte can produce
  localparam int RCNT_W       = 3;   // holds 0..MAX_RANGES
  localparam int ID_WIDTH_DEF = 32;

  // One range found in the current byte, as bit offsets.
  typedef struct packed {
    logic                 carry;   // start is the run opened in an earlier byte
    logic                 e_prev;  // end is bit 7 of the previous byte
    logic [BIT_IDX_W-1:0] s_idx;
    logic [BIT_IDX_W-1:0] e_idx;
  } range_sel_t;

  // Per-byte summary from the scanner.
  typedef struct packed {
    logic [RCNT_W-1:0]    cnt;          // ranges closed by this byte
    logic                 open_nxt;     // a run is open after this byte
    logic                 first_fresh;  // that run started in this byte
    logic [BIT_IDX_W-1:0] first_idx;    // its start bit
  } scan_res_t;

endpackage

// ===== rtl/core/bfre_scan.sv =====
// Byte scanner: finds the free runs closed by one bitmap byte.
// Pure combinational; depends on bfre_pkg.
module bfre_scan (
  input  logic [bfre_pkg::BYTE_W-1:0] byte_i,
  input  logic                        last_i,
  input  logic                        run_open_i,
  output bfre_pkg::scan_res_t         res_o,
  output bfre_pkg::range_sel_t        rng_o [bfre_pkg::MAX_RANGES]
);
  import bfre_pkg::*;

  range_sel_t rng_v [MAX_RANGES];

  always_comb begin
    logic                 open;
    logic                 carry;
    logic [BIT_IDX_W-1:0] sidx;
    logic [RCNT_W-1:0]    cnt;
    open  = run_open_i;
    carry = run_open_i;
    sidx  = '0;
    cnt   = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      rng_v[i] = '0;
    end
    for (int b = 0; b < BYTE_W; b++) begin
      if (!byte_i[b]) begin
        if (!open) begin
          open  = 1'b1;
          carry = 1'b0;
          sidx  = BIT_IDX_W'(b);
        end
      end else if (open) begin
        open               = 1'b0;
        rng_v[cnt].carry   = carry;
        rng_v[cnt].s_idx   = sidx;
        // used bit 0 closes a run that ended on the previous byte
        rng_v[cnt].e_prev  = (b == 0);
        rng_v[cnt].e_idx   = (b == 0) ? {BIT_IDX_W{1'b1}} : BIT_IDX_W'(b - 1);
        cnt                = cnt + 1'b1;
      end
    end
    res_o.first_fresh = open & ~carry;
    res_o.first_idx   = sidx;
    if (last_i && open) begin
      // close at bit 7 of the final byte
      rng_v[cnt].carry  = carry;
      rng_v[cnt].s_idx  = sidx;
      rng_v[cnt].e_prev = 1'b0;
      rng_v[cnt].e_idx  = {BIT_IDX_W{1'b1}};
      cnt               = cnt + 1'b1;
    end
    res_o.cnt      = cnt;
    res_o.open_nxt = open & ~last_i;
  end

  assign rng_o = rng_v;

endmodule

// ===== rtl/core/bfre_out_reg.sv =====
// Output register for the range stream: holds one range until taken.
// Depends on bfre_pkg.
module bfre_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_i,
  input  logic [bfre_pkg::ID_OUT_W-1:0] start_i,
  input  logic [bfre_pkg::ID_OUT_W-1:0] end_i,
  input  logic                          last_i,
  output logic                          rdy_o,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*bfre_pkg::ID_OUT_W-1:0] out_tdata,  // range_start, range_end
  output logic                          out_tlast     // last_of_item
);
  import bfre_pkg::*;

  logic                  valid_r;
  logic [ID_OUT_W-1:0]   start_r;
  logic [ID_OUT_W-1:0]   end_r;
  logic                  last_r;

  // free, or emptying this cycle
  assign rdy_o = ~valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy_o) begin
      valid_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && load_i) begin
      start_r <= start_i;
      end_r   <= end_i;
      last_r  <= last_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {end_r, start_r};
  assign out_tlast  = last_r;

endmodule

// ===== rtl/core/bitmap_free_range_extractor_unit.sv =====
// Top level of the bitmap free-range extractor.
// Depends on bfre_pkg, bfre_scan and bfre_out_reg.
//
// Usage:
//  - in_*  : one bitmap byte per item, bit 0 first, clear bit = free entry.
//            in_tlast marks the final byte of the bitmap; it closes any open
//            run and restarts the bit position at zero.
//  - out_* : one free run per item as inclusive start/end IDs, where
//            ID = base_id + bit position (mod 2^ID_WIDTH, cut to 32 bits).
//            out_tlast flags the last range produced by a given byte.
//  - cfg_* : write of base_id, registered on cfg_wen; write while idle.
// Timing: a byte sits in a holding register; the scanner finds its ranges
// and one range per cycle is loaded into the output register while it is
// ready to take one. The first range passes through the holding register
// and then the output register. A byte with no ranges retires without
// output; a byte with k ranges (up to 5) sends them one at a time.
// A new byte is accepted in the same cycle the held byte retires.
// Receiver stall: the output register holds its range, the held byte
// waits while it still has ranges to send, and in_tready drops until the range is taken.
// Reset: position, run state and base_id clear; no items in flight.
module bitmap_free_range_extractor_unit #(
  parameter int ID_WIDTH = bfre_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // bitmap byte stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfre_pkg::BYTE_W-1:0]     in_tdata,   // bitmap_byte
  input  logic                            in_tlast,   // last_byte
  // free range stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*bfre_pkg::ID_OUT_W-1:0] out_tdata,  // range_start, range_end
  output logic                            out_tlast,  // last_of_item
  // base_id register
  input  logic                            cfg_wen,
  input  logic [bfre_pkg::BASE_W-1:0]     cfg_wdata
);
  import bfre_pkg::*;

  // sum wide enough for base + position, then cut to ID_WIDTH
  localparam int SUM_W = (ID_WIDTH > POS_W) ? ID_WIDTH : POS_W;
  localparam logic [SUM_W-1:0] ID_MASK = {SUM_W{1'b1}} >> (SUM_W - ID_WIDTH);

  function automatic logic [ID_OUT_W-1:0] id_of(input logic [BASE_W-1:0] b,
                                                 input logic [POS_W-1:0]  p);
    logic [SUM_W-1:0] s;
    s = (SUM_W'(b) + SUM_W'(p)) & ID_MASK;
    return s[ID_OUT_W-1:0];
  endfunction

  // config
  logic [BASE_W-1:0]    base_r;

  // held byte
  logic                 hold_valid_r;
  logic [BYTE_W-1:0]    hold_byte_r;
  logic                 hold_last_r;
  logic [RCNT_W-1:0]    idx_r;        // next range of the held byte to send

  // run state; position is always byte aligned: {cnt_r, bit}
  logic                 run_open_r;
  logic [ID_OUT_W-1:0]  run_first_r;
  logic [BCNT_W-1:0]    cnt_r;
  logic [BCNT_W-1:0]    cnt_m1_r;     // cnt_r - 1, for runs ending on the prior byte

  scan_res_t            res;
  range_sel_t           rng [MAX_RANGES];
  range_sel_t           cur;

  logic                 out_rdy;
  logic                 has_rng;
  logic                 last_rng;
  logic                 emit;
  logic                 retire;
  logic                 in_acc;
  logic [ID_OUT_W-1:0]  start_id;
  logic [ID_OUT_W-1:0]  end_id;

  bfre_scan u_scan (
    .byte_i     (hold_byte_r),
    .last_i     (hold_last_r),
    .run_open_i (run_open_r),
    .res_o      (res),
    .rng_o      (rng)
  );

  assign cur      = rng[idx_r];
  assign has_rng  = (res.cnt != '0);
  assign last_rng = (idx_r == RCNT_W'(res.cnt - 1'b1));
  assign emit     = hold_valid_r & has_rng & out_rdy;
  // held byte is done when it had no ranges or its final range goes out
  assign retire   = hold_valid_r & (~has_rng | (out_rdy & last_rng));
  assign in_tready = ~hold_valid_r | retire;
  assign in_acc   = in_tvalid & in_tready;

  assign start_id = cur.carry ? run_first_r : id_of(base_r, {cnt_r, cur.s_idx});
  assign end_id   = id_of(base_r, {(cur.e_prev ? cnt_m1_r : cnt_r), cur.e_idx});

  bfre_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (emit),
    .start_i    (start_id),
    .end_i      (end_id),
    .last_i     (last_rng),
    .rdy_o      (out_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wen) begin
      base_r <= cfg_wdata;
    end
  end

  // holding register and range index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (in_acc) begin
        hold_valid_r <= 1'b1;
      end else if (retire) begin
        hold_valid_r <= 1'b0;
      end
      if (retire) begin
        idx_r <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_byte_r <= in_tdata;
      hold_last_r <= in_tlast;
    end
  end

  // run state advances once per retired byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_first_r <= '0;
      cnt_r       <= '0;
      cnt_m1_r    <= '1;
    end else if (retire) begin
      run_open_r <= res.open_nxt;
      if (res.first_fresh) begin
        run_first_r <= id_of(base_r, {cnt_r, res.first_idx});
      end
      if (hold_last_r) begin
        cnt_r    <= '0;
        cnt_m1_r <= '1;
      end else begin
        cnt_r    <= cnt_r + 1'b1;
        cnt_m1_r <= cnt_r;
      end
    end
  end

endmodule
